[rtl/occ_pkg.sv]
// Package for the ones' complement checksum accumulator.
// Holds beat geometry constants, shared types and the end-around-carry adder.
// No dependencies.
package occ_pkg;

   // Beat geometry
   localparam int BEAT_BYTES = 32;
   localparam int LANE_BYTES = 8;
   localparam int LANES      = BEAT_BYTES / LANE_BYTES;
   localparam int WORD_W     = 8 * LANE_BYTES;
   localparam int COUNT_W    = 6;
   localparam int LANE_IDX_W = $clog2(LANES);
   localparam int BYTE_IDX_W = $clog2(LANE_BYTES);

   typedef logic [WORD_W-1:0]     word_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [LANE_IDX_W-1:0] lane_idx_type;

   // Load enables for the two register levels of the merge tree
   typedef struct packed {
      logic pair_en;
      logic beat_en;
   } merge_en_type;

   // Add two words, feeding the carry out of the top bit back in at bit 0
   function automatic word_type add_ea(input word_type a, input word_type b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
   endfunction

endpackage

[rtl/occ_lane.sv]
// One data lane: zeroes the bytes of its word that lie at or past the byte count.
// Depends on occ_pkg.
module occ_lane (
   input  logic                 clock,
   input  logic                 load,
   input  occ_pkg::lane_idx_type lane_idx,
   input  occ_pkg::word_type    word,
   input  occ_pkg::count_type   byte_count,
   output occ_pkg::word_type    masked
);
   import occ_pkg::*;

   word_type masked_ff;
   word_type masked_in;

   // Keep byte j when its position in the beat is below the byte count
   always_comb begin
      logic [LANE_IDX_W+BYTE_IDX_W-1:0] pos;
      masked_in = '0;
      for (int j = 0; j < LANE_BYTES; j++) begin
         pos = {lane_idx, BYTE_IDX_W'(j)};
         if (COUNT_W'(pos) < byte_count) begin
            masked_in[8*j +: 8] = word[8*j +: 8];
         end
      end
   end

   // Hold the masked word for the merge tree
   always_ff @(posedge clock) begin
      if (load) begin
         masked_ff <= masked_in;
      end
   end

   assign masked = masked_ff;

endmodule

[rtl/occ_merge.sv]
// Merge tree: folds the four lane words into one beat sum over two register levels.
// Depends on occ_pkg (add_ea, types).
module occ_merge (
   input  logic                 clock,
   input  occ_pkg::merge_en_type en,
   input  occ_pkg::word_type    lane_word [occ_pkg::LANES],
   output occ_pkg::word_type    beat_sum
);
   import occ_pkg::*;

   word_type pair0_ff;
   word_type pair1_ff;
   word_type beat_ff;

   // First level: add lane pairs
   always_ff @(posedge clock) begin
      if (en.pair_en) begin
         pair0_ff <= add_ea(lane_word[0], lane_word[1]);
         pair1_ff <= add_ea(lane_word[2], lane_word[3]);
      end
   end

   // Second level: add the two pair sums
   always_ff @(posedge clock) begin
      if (en.beat_en) begin
         beat_ff <= add_ea(pair0_ff, pair1_ff);
      end
   end

   assign beat_sum = beat_ff;

endmodule

[rtl/ones_complement_checksum_accumulator.sv]
// Top level of the ones' complement checksum accumulator (unfolded 64-bit sum).
// Depends on occ_pkg, occ_lane and occ_merge.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | word0..3, byte_count, first, last, seed
//   rsp     | out       | rsp_valid / rsp_stall  | sum
//
// Takes one 32-byte request per cycle while req_stall is low; the result is registered as its last beat leaves stage 3.
// Lanes mask, two merge levels add, then one end-around add updates the accumulator.
// Reset is synchronous and clears the pipeline valids, the accumulator and rsp_valid.
// A held result stalls only beats marked last; req_stall rises once the pipeline fills.
module ones_complement_checksum_accumulator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  occ_pkg::word_type   req_word0,
   input  occ_pkg::word_type   req_word1,
   input  occ_pkg::word_type   req_word2,
   input  occ_pkg::word_type   req_word3,
   input  occ_pkg::count_type  req_byte_count,
   input  logic                req_first,
   input  logic                req_last,
   input  occ_pkg::word_type   req_seed,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output occ_pkg::word_type   rsp_sum
);
   import occ_pkg::*;

   word_type     req_word [LANES];
   word_type     lane_word [LANES];
   word_type     beat_sum;
   merge_en_type merge_en;

   // Stage valids and the control that rides along each request
   logic     v1_ff, v2_ff, v3_ff;
   logic     v1_in, v2_in, v3_in;
   logic     first1_ff, first2_ff, first3_ff;
   logic     last1_ff, last2_ff, last3_ff;
   word_type seed1_ff, seed2_ff, seed3_ff;

   word_type acc_ff;
   word_type acc_in;
   word_type acc_base;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   word_type rsp_sum_ff;

   logic load1, load2, load3, adv3;

   assign req_word[0] = req_word0;
   assign req_word[1] = req_word1;
   assign req_word[2] = req_word2;
   assign req_word[3] = req_word3;

   // Advance: non-last beats never wait on the result register
   assign adv3  = v3_ff && (!last3_ff || !rsp_valid_ff || !rsp_stall);
   assign load3 = v2_ff && (!v3_ff || adv3);
   assign load2 = v1_ff && (!v2_ff || load3);
   assign req_stall = v1_ff && !load2;
   assign load1 = req_valid && !req_stall;

   assign merge_en.pair_en = load2;
   assign merge_en.beat_en = load3;

   // Lanes
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      occ_lane u_lane (
         .clock      (clock),
         .load       (load1),
         .lane_idx   (LANE_IDX_W'(i)),
         .word       (req_word[i]),
         .byte_count (req_byte_count),
         .masked     (lane_word[i])
      );
   end

   occ_merge u_merge (
      .clock     (clock),
      .en        (merge_en),
      .lane_word (lane_word),
      .beat_sum  (beat_sum)
   );

   // Accumulate: seed on a first beat, else continue from the running sum
   assign acc_base = first3_ff ? seed3_ff : acc_ff;
   assign acc_in   = add_ea(acc_base, beat_sum);

   // Stage valid next values
   assign v1_in = load1 ? 1'b1 : (load2 ? 1'b0 : v1_ff);
   assign v2_in = load2 ? 1'b1 : (load3 ? 1'b0 : v2_ff);
   assign v3_in = load3 ? 1'b1 : (adv3 ? 1'b0 : v3_ff);
   assign rsp_valid_in = (adv3 && last3_ff) ? 1'b1 :
                         (rsp_stall ? rsp_valid_ff : 1'b0);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv3) begin
            acc_ff <= acc_in;
         end
      end
   end

   // Carry request control alongside the data
   always_ff @(posedge clock) begin
      if (load1) begin
         first1_ff <= req_first;
         last1_ff  <= req_last;
         seed1_ff  <= req_seed;
      end
      if (load2) begin
         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
         seed2_ff  <= seed1_ff;
      end
      if (load3) begin
         first3_ff <= first2_ff;
         last3_ff  <= last2_ff;
         seed3_ff  <= seed2_ff;
      end
      if (adv3 && last3_ff) begin
         rsp_sum_ff <= acc_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;

`ifndef NO_ASSERTIONS
   // Reset leaves the accumulator at zero
   a_acc_reset: assert property (@(posedge clock) reset |=> acc_ff == '0)
      else $error("accumulator not cleared by reset");

   // Adding a zero beat to a running sum leaves it unchanged
   a_zero_beat: assert property (@(posedge clock) disable iff (reset)
      (adv3 && !first3_ff && beat_sum == '0) |=> acc_ff == $past(acc_ff))
      else $error("zero beat changed the accumulator");

   // End-around add yields zero only from two zero operands
   a_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (adv3 && acc_in == '0) |-> (acc_base == '0 && beat_sum == '0))
      else $error("end-around carry lost");

   // A last beat leaving the pipeline shows up as the result
   a_result: assert property (@(posedge clock) disable iff (reset)
      (adv3 && last3_ff) |=> (rsp_valid && rsp_sum == $past(acc_in)))
      else $error("last beat did not produce its result");

   // Stall only with a full first stage
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("stall raised with empty input stage");
`endif

endmodule
